[hdl/half_single_float_converter_macros.svh]
// ----------------------------------------------------------------------------
// half_single_float_converter_macros
// assertion macros used by the converter top level
// ----------------------------------------------------------------------------
`ifndef HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSFC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HSFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/hsfc_pkg.sv]
// ----------------------------------------------------------------------------
// hsfc_pkg
// types and constants for the half/single float converter
// ----------------------------------------------------------------------------
package hsfc_pkg;

	typedef enum logic {
		CMD_H2S = 1'b0,
		CMD_S2H = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_ZERO    = 2'd0,
		CLS_SUB     = 2'd1,
		CLS_NORM    = 2'd2,
		CLS_SPECIAL = 2'd3
	} cls_t;

	localparam logic [4:0] HALF_EXP_MAX  = 5'h1f;
	localparam logic [7:0] SGL_EXP_MAX   = 8'hff;
	localparam logic [7:0] SGL_OVF_EXP   = 8'd143;
	localparam logic [7:0] SGL_UNF_EXP   = 8'd112;
	localparam logic [7:0] BIAS_DIFF     = 8'd112;
	localparam logic [7:0] HALF_INF_EXP  = 8'd31;
	localparam logic [9:0] HALF_NAN_MANT = 10'h3ff;

	typedef struct packed {
		cmd_t       cmd;
		logic       sign;
		cls_t       cls;
		logic       nan;
		logic [7:0] exp;
		logic [9:0] mant;
		logic [3:0] lz;
	} s1_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       sign;
		logic [7:0] exp;
		logic [9:0] mant;
	} s2_t;

endpackage

[hdl/half_single_float_converter.sv]
// ----------------------------------------------------------------------------
// half_single_float_converter
// binary16 <-> binary32 bit-pattern converter, three-stage pipeline
// ----------------------------------------------------------------------------
// Takes one item per cycle while result_ready stays high and passes each
// item through the three pipeline registers (decode, normalize, pack); a
// stall on the result side holds every stage without dropping or repeating
// an item. command 0 turns the low 16 bits of operand_bits into a single;
// command 1 turns a single into a half in the low 16 bits of result_bits,
// truncating the mantissa, saturating to infinity and flushing small
// values to +0.
`include "half_single_float_converter_macros.svh"

module half_single_float_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        operand_valid,
	output logic        operand_ready,
	input  logic        command,
	input  logic [31:0] operand_bits,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] result_bits
);

	logic          valid_s1;
	logic          valid_s2;
	logic          ready_s2;
	logic          ready_s3;
	hsfc_pkg::s1_t data_s1;
	hsfc_pkg::s2_t data_s2;

	hsfc_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (operand_valid),
		.up_ready     (operand_ready),
		.command      (command),
		.operand_bits (operand_bits),
		.valid_s1     (valid_s1),
		.down_ready   (ready_s2),
		.data_s1      (data_s1)
	);

	hsfc_normalize u_normalize (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.up_ready   (ready_s2),
		.data_s1    (data_s1),
		.valid_s2   (valid_s2),
		.down_ready (ready_s3),
		.data_s2    (data_s2)
	);

	hsfc_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.up_ready   (ready_s3),
		.data_s2    (data_s2),
		.valid_s3   (result_valid),
		.down_ready (result_ready),
		.result_s3  (result_bits)
	);

	// no bubbles while the consumer takes every item
	`HSFC_ASSERT_IMPLIES(a_no_bubble, result_ready, operand_ready, "pipeline stalls with free output")

	// an item in stage 1 moves to stage 2 whenever stage 2 can take it
	`HSFC_ASSERT_NEXT(a_s1_advance, valid_s1 && ready_s2, valid_s2, "stage 1 item lost")

	// half exponents never exceed five bits
	`HSFC_ASSERT_IMPLIES(a_half_exp, valid_s2 && (data_s2.cmd == hsfc_pkg::CMD_S2H), data_s2.exp[7:5] == 3'b000, "half exponent out of range")

	// subnormal class only arises for half operands with a nonzero significand
	`HSFC_ASSERT_IMPLIES(a_sub_class, valid_s1 && (data_s1.cls == hsfc_pkg::CLS_SUB), (data_s1.cmd == hsfc_pkg::CMD_H2S) && (data_s1.lz <= 4'd9), "bad subnormal decode")

endmodule

[hdl/hsfc_decode.sv]
// ----------------------------------------------------------------------------
// hsfc_decode
// stage 1: field split, value class and leading-zero count
// ----------------------------------------------------------------------------
module hsfc_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  logic             command,
	input  logic [31:0]      operand_bits,
	output logic             valid_s1,
	input  logic             down_ready,
	output hsfc_pkg::s1_t    data_s1
);

	hsfc_pkg::s1_t d;
	logic [4:0]    e5;
	logic [7:0]    e8;
	logic [9:0]    hm;
	logic [3:0]    lz;

	assign up_ready = !valid_s1 || down_ready;
	assign e5 = operand_bits[14:10];
	assign e8 = operand_bits[30:23];
	assign hm = operand_bits[9:0];

	// leading zeros of the half significand
	always_comb begin
		lz = 4'd10;
		for (int i = 0; i < 10; i++) begin
			if (hm[i]) begin
				lz = 4'(9 - i);
			end
		end
	end

	always_comb begin
		d      = '0;
		d.lz   = lz;
		if (command == hsfc_pkg::CMD_H2S) begin
			d.cmd  = hsfc_pkg::CMD_H2S;
			d.sign = operand_bits[15];
			d.exp  = {3'b000, e5};
			d.mant = hm;
			d.nan  = 1'b0;
			if (e5 == 5'd0) begin
				d.cls = (hm == 10'd0) ? hsfc_pkg::CLS_ZERO : hsfc_pkg::CLS_SUB;
			end else if (e5 == hsfc_pkg::HALF_EXP_MAX) begin
				d.cls = hsfc_pkg::CLS_SPECIAL;
			end else begin
				d.cls = hsfc_pkg::CLS_NORM;
			end
		end else begin
			d.cmd  = hsfc_pkg::CMD_S2H;
			d.sign = operand_bits[31];
			d.exp  = e8;
			d.mant = operand_bits[22:13];
			d.nan  = (e8 == hsfc_pkg::SGL_EXP_MAX) && (operand_bits[22:0] != 23'd0);
			if (e8 >= hsfc_pkg::SGL_OVF_EXP) begin
				d.cls = hsfc_pkg::CLS_SPECIAL;
			end else if (e8 <= hsfc_pkg::SGL_UNF_EXP) begin
				d.cls = hsfc_pkg::CLS_ZERO;
			end else begin
				d.cls = hsfc_pkg::CLS_NORM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= d;
		end
	end

endmodule

[hdl/hsfc_normalize.sv]
// ----------------------------------------------------------------------------
// hsfc_normalize
// stage 2: subnormal shift, rebias and special-value selection
// ----------------------------------------------------------------------------
module hsfc_normalize (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	output logic             up_ready,
	input  hsfc_pkg::s1_t    data_s1,
	output logic             valid_s2,
	input  logic             down_ready,
	output hsfc_pkg::s2_t    data_s2
);

	hsfc_pkg::s2_t d;
	logic [9:0]    sub_mant;

	assign up_ready = !valid_s2 || down_ready;
	assign sub_mant = data_s1.mant << (data_s1.lz + 4'd1);

	always_comb begin
		d      = '0;
		d.cmd  = data_s1.cmd;
		d.sign = data_s1.sign;
		if (data_s1.cmd == hsfc_pkg::CMD_H2S) begin
			case (data_s1.cls)
				hsfc_pkg::CLS_ZERO: begin
					d.exp  = 8'd0;
					d.mant = 10'd0;
				end
				hsfc_pkg::CLS_SUB: begin
					d.exp  = hsfc_pkg::BIAS_DIFF - {4'b0000, data_s1.lz};
					d.mant = sub_mant;
				end
				hsfc_pkg::CLS_NORM: begin
					d.exp  = data_s1.exp + hsfc_pkg::BIAS_DIFF;
					d.mant = data_s1.mant;
				end
				default: begin
					d.exp  = hsfc_pkg::SGL_EXP_MAX;
					d.mant = data_s1.mant;
				end
			endcase
		end else begin
			case (data_s1.cls)
				hsfc_pkg::CLS_SPECIAL: begin
					d.exp  = hsfc_pkg::HALF_INF_EXP;
					d.mant = data_s1.nan ? hsfc_pkg::HALF_NAN_MANT : 10'd0;
				end
				hsfc_pkg::CLS_NORM: begin
					d.exp  = data_s1.exp - hsfc_pkg::BIAS_DIFF;
					d.mant = data_s1.mant;
				end
				default: begin
					// underflow flushes to positive zero
					d.sign = 1'b0;
					d.exp  = 8'd0;
					d.mant = 10'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && valid_s1) begin
			data_s2 <= d;
		end
	end

endmodule

[hdl/hsfc_pack.sv]
// ----------------------------------------------------------------------------
// hsfc_pack
// stage 3: result word assembly and output register
// ----------------------------------------------------------------------------
module hsfc_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	output logic             up_ready,
	input  hsfc_pkg::s2_t    data_s2,
	output logic             valid_s3,
	input  logic             down_ready,
	output logic [31:0]      result_s3
);

	logic [31:0] word;

	assign up_ready = !valid_s3 || down_ready;

	always_comb begin
		if (data_s2.cmd == hsfc_pkg::CMD_H2S) begin
			word = {data_s2.sign, data_s2.exp, data_s2.mant, 13'd0};
		end else begin
			word = {16'd0, data_s2.sign, data_s2.exp[4:0], data_s2.mant};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && valid_s2) begin
			result_s3 <= word;
		end
	end

endmodule
